// ----- src/widiv_pkg.sv -----
`timescale 1ns / 1ps

package widiv_pkg;

   localparam int HALF_BITS = 64;
   localparam int OPER_BITS = 128;

   // Request tdata: dividend_low, dividend_high, divisor_low, divisor_high
   localparam int REQ_DATA_BITS = 4 * HALF_BITS;
   // Request tuser: signed_mode, want_remainder
   localparam int REQ_USER_BITS = 2;
   // Response tdata: result_low, result_high
   localparam int RSP_DATA_BITS = 2 * HALF_BITS;
   // Response tuser: ok
   localparam int RSP_USER_BITS = 1;

   localparam int USER_SIGNED_BIT = 0;
   localparam int USER_REM_BIT    = 1;

   // Per-request flags carried down the pipeline next to the data
   typedef struct packed {
      logic neg_quo;
      logic neg_rem;
      logic want_rem;
      logic div_zero;
   } ctrl_type;

endpackage

// ----- src/widiv_front.sv -----
`timescale 1ns / 1ps

module widiv_front #(
   parameter int WORD_BITS = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [widiv_pkg::REQ_DATA_BITS-1:0]    in_data,
   input  logic [widiv_pkg::REQ_USER_BITS-1:0]    in_user,
   output logic                                   out_valid,
   output logic [WORD_BITS-1:0]                   out_rem,
   output logic [WORD_BITS-1:0]                   out_nq,
   output logic [WORD_BITS-1:0]                   out_div,
   output widiv_pkg::ctrl_type                    out_ctrl
);

   logic [widiv_pkg::OPER_BITS-1:0] dvd_full;
   logic [widiv_pkg::OPER_BITS-1:0] dvs_full;
   logic [WORD_BITS-1:0]            dvd;
   logic [WORD_BITS-1:0]            dvs;
   logic                            sgn;
   logic                            na;
   logic                            nb;
   logic [WORD_BITS-1:0]            dvd_abs;
   logic [WORD_BITS-1:0]            dvs_abs;
   widiv_pkg::ctrl_type             ctrl;

   logic                            valid_ff;
   logic [WORD_BITS-1:0]            nq_ff;
   logic [WORD_BITS-1:0]            div_ff;
   widiv_pkg::ctrl_type             ctrl_ff;

   always_comb begin
      dvd_full = in_data[widiv_pkg::OPER_BITS-1:0];
      dvs_full = in_data[widiv_pkg::REQ_DATA_BITS-1:widiv_pkg::OPER_BITS];
      dvd      = dvd_full[WORD_BITS-1:0];
      dvs      = dvs_full[WORD_BITS-1:0];
      sgn      = in_user[widiv_pkg::USER_SIGNED_BIT];
      na       = sgn & dvd[WORD_BITS-1];
      nb       = sgn & dvs[WORD_BITS-1];
      dvd_abs  = na ? (~dvd + WORD_BITS'(1)) : dvd;
      dvs_abs  = nb ? (~dvs + WORD_BITS'(1)) : dvs;
      ctrl.neg_quo  = na ^ nb;
      ctrl.neg_rem  = na;
      ctrl.want_rem = in_user[widiv_pkg::USER_REM_BIT];
      ctrl.div_zero = (dvs == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         nq_ff   <= dvd_abs;
         div_ff  <= dvs_abs;
         ctrl_ff <= ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = '0;
   assign out_nq    = nq_ff;
   assign out_div   = div_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

// ----- src/widiv_step.sv -----
`timescale 1ns / 1ps

// One restoring step: shift the next dividend bit into the partial remainder,
// subtract the divisor when it fits, shift the quotient bit in behind.
module widiv_step #(
   parameter int WORD_BITS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [WORD_BITS-1:0]   in_rem,
   input  logic [WORD_BITS-1:0]   in_nq,
   input  logic [WORD_BITS-1:0]   in_div,
   input  widiv_pkg::ctrl_type    in_ctrl,
   output logic                   out_valid,
   output logic [WORD_BITS-1:0]   out_rem,
   output logic [WORD_BITS-1:0]   out_nq,
   output logic [WORD_BITS-1:0]   out_div,
   output widiv_pkg::ctrl_type    out_ctrl
);

   logic [WORD_BITS:0]     rem_sh;
   logic [WORD_BITS:0]     diff;
   logic                   take;
   logic [WORD_BITS-1:0]   rem_in;
   logic [WORD_BITS-1:0]   nq_in;

   logic                   valid_ff;
   logic [WORD_BITS-1:0]   rem_ff;
   logic [WORD_BITS-1:0]   nq_ff;
   logic [WORD_BITS-1:0]   div_ff;
   widiv_pkg::ctrl_type    ctrl_ff;

   always_comb begin
      // top bit of the shifted remainder is the carry out; it forces a subtract
      rem_sh = {in_rem, in_nq[WORD_BITS-1]};
      diff   = rem_sh - {1'b0, in_div};
      take   = ~diff[WORD_BITS];
      rem_in = take ? diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
      nq_in  = {in_nq[WORD_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         div_ff  <= in_div;
         ctrl_ff <= in_ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_div   = div_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

// ----- src/widiv_back.sv -----
`timescale 1ns / 1ps

module widiv_back #(
   parameter int WORD_BITS = 128
) (
   input  logic [WORD_BITS-1:0]                   quo,
   input  logic [WORD_BITS-1:0]                   rem,
   input  widiv_pkg::ctrl_type                    ctrl,
   output logic [widiv_pkg::RSP_DATA_BITS-1:0]    result,
   output logic                                   ok
);

   logic [WORD_BITS-1:0] sel;
   logic                 neg;
   logic [WORD_BITS-1:0] res;

   always_comb begin
      sel = ctrl.want_rem ? rem : quo;
      neg = ctrl.want_rem ? ctrl.neg_rem : ctrl.neg_quo;
      res = neg ? (~sel + WORD_BITS'(1)) : sel;
      result = '0;
      ok     = 1'b0;
      // zero divisor: drop the result and flag it
      if (!ctrl.div_zero) begin
         result[WORD_BITS-1:0] = res;
         ok = 1'b1;
      end
   end

endmodule

// ----- src/wide_integer_divider_core.sv -----
`timescale 1ns / 1ps

// Channel    Dir  Handshake             Payload
// req_       in   req_tvalid/tready     tdata: dividend, divisor; tuser: mode flags
// rsp_       out  rsp_tvalid/tready     tdata: result; tuser: ok
//
// One request enters per cycle while the skid slot is empty; each passes through
// a sign-handling register, one restoring subtract stage per quotient bit, and
// the output register, which captures the result after its sign and select.
// Reset clears every stage valid bit and the output and skid slot valid bits.
// A stalled response is held in the output register; the pipeline advances
// until a result lands in the skid slot, then holds until the slot drains.
module wide_integer_divider_core #(
   parameter int WORD_BITS = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // dividend_low, dividend_high, divisor_low, divisor_high
   input  logic [widiv_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // signed_mode, want_remainder
   input  logic [widiv_pkg::REQ_USER_BITS-1:0]    req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // result_low, result_high
   output logic [widiv_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // ok
   output logic [widiv_pkg::RSP_USER_BITS-1:0]    rsp_tuser
);

   logic                  adv;

   logic                  stg_valid [0:WORD_BITS];
   logic [WORD_BITS-1:0]  stg_rem   [0:WORD_BITS];
   logic [WORD_BITS-1:0]  stg_nq    [0:WORD_BITS];
   logic [WORD_BITS-1:0]  stg_div   [0:WORD_BITS];
   widiv_pkg::ctrl_type   stg_ctrl  [0:WORD_BITS];

   logic [widiv_pkg::RSP_DATA_BITS-1:0] back_result;
   logic                                back_ok;

   logic                                out_valid_ff, out_valid_in;
   logic [widiv_pkg::RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                                out_ok_ff, out_ok_in;
   logic                                skid_valid_ff, skid_valid_in;
   logic [widiv_pkg::RSP_DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                                skid_ok_ff, skid_ok_in;
   logic                                out_free;

   assign adv        = ~skid_valid_ff;
   assign req_tready = adv;

   widiv_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_user   (req_tuser),
      .out_valid (stg_valid[0]),
      .out_rem   (stg_rem[0]),
      .out_nq    (stg_nq[0]),
      .out_div   (stg_div[0]),
      .out_ctrl  (stg_ctrl[0])
   );

   for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
      widiv_step #(.WORD_BITS(WORD_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (adv),
         .in_valid  (stg_valid[k]),
         .in_rem    (stg_rem[k]),
         .in_nq     (stg_nq[k]),
         .in_div    (stg_div[k]),
         .in_ctrl   (stg_ctrl[k]),
         .out_valid (stg_valid[k+1]),
         .out_rem   (stg_rem[k+1]),
         .out_nq    (stg_nq[k+1]),
         .out_div   (stg_div[k+1]),
         .out_ctrl  (stg_ctrl[k+1])
      );
   end

   widiv_back #(.WORD_BITS(WORD_BITS)) u_back (
      .quo    (stg_nq[WORD_BITS]),
      .rem    (stg_rem[WORD_BITS]),
      .ctrl   (stg_ctrl[WORD_BITS]),
      .result (back_result),
      .ok     (back_ok)
   );

   always_comb begin
      out_free      = ~out_valid_ff | rsp_tready;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_data_in   = out_data_ff;
      out_ok_in     = out_ok_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_ok_in    = skid_ok_ff;
      if (skid_valid_ff) begin
         // drain the skid slot first; the pipeline is held meanwhile
         out_valid_in = 1'b1;
         if (out_free) begin
            out_data_in   = skid_data_ff;
            out_ok_in     = skid_ok_ff;
            skid_valid_in = 1'b0;
         end
      end else if (stg_valid[WORD_BITS]) begin
         out_valid_in = 1'b1;
         if (out_free) begin
            out_data_in = back_result;
            out_ok_in   = back_ok;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = back_result;
            skid_ok_in    = back_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_ok_ff    <= out_ok_in;
      skid_data_ff <= skid_data_in;
      skid_ok_ff   <= skid_ok_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ok_ff;

endmodule
